@@ rtl/cflts_pkg.sv @@
package cflts_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Back pipeline stage map. Stage 0 is loaded from the queue.
    localparam int DIV1_LAST  = 64;   // kinetic energy quotient, one bit per stage
    localparam int SQM_LAST   = 32;   // metric norms, run beside the first divide
    localparam int K_PRES     = 65;
    localparam int K_GP       = 66;
    localparam int DIV2_LAST  = 119;  // a2 = g*p / rho, 53 quotient bits
    localparam int K_SQI      = 120;
    localparam int SQA_LAST   = 155;  // sound speed root, 35 digits
    localparam int K_MUL      = 156;
    localparam int K_SPD      = 157;
    localparam int K_MAX      = 158;
    localparam int NUM_STAGES = 195;  // last divide stage is 194

    localparam logic [18:0] ONE_HR    = 19'd65536;
    localparam logic [62:0] SPEED_CAP = 63'h4000_0000_0000_0000;
    localparam logic [30:0] DT_MAX    = 31'h7fff_ffff;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_RHO = 2'd1;
    localparam logic [1:0] ST_NEG_P    = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    localparam logic CFG_HEAT_RATIO = 1'b0;
    localparam logic CFG_COURANT    = 1'b1;

    typedef struct packed {
        logic        zero;
        logic [30:0] rho;
        logic [30:0] e;
        logic [31:0] vxi;
        logic [31:0] veta;
        logic [63:0] msq;
        logic [63:0] sqx;
        logic [63:0] sqe;
    } t_item;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] den;
        logic [63:0] quo;
    } t_dv;

    typedef struct packed {
        logic [69:0] num;
        logic [39:0] rem;
        logic [35:0] root;
    } t_sq;

    typedef struct packed {
        logic        flag;
        logic [1:0]  stat;
        logic [30:0] rho;
        logic [30:0] e;
        logic [31:0] vxi;
        logic [31:0] veta;
        t_dv         dv;
        t_sq         sx;
        t_sq         se;
        t_sq         sa;
        logic [33:0] pv;
        logic [66:0] px;
        logic [66:0] pe;
        logic [62:0] tx;
        logic [62:0] te;
    } t_work;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // One restoring divide step: one quotient bit.
    function automatic t_dv div_step(input t_dv w);
        t_dv         o;
        logic [64:0] t;
        logic [64:0] d;
        o = w;
        t = {w.rem, w.num[63]};
        d = {1'b0, w.den};
        if (t >= d) begin
            t = t - d;
            o.quo = {w.quo[62:0], 1'b1};
        end else begin
            o.quo = {w.quo[62:0], 1'b0};
        end
        o.rem = t[63:0];
        o.num = {w.num[62:0], 1'b0};
        return o;
    endfunction

    // One digit of the square root: consumes the top two bits of num.
    function automatic t_sq sq_step(input t_sq w);
        t_sq         o;
        logic [39:0] r;
        logic [39:0] c;
        o = w;
        r = {w.rem[37:0], w.num[69:68]};
        c = {2'b00, w.root, 2'b01};
        if (r >= c) begin
            o.rem  = r - c;
            o.root = {w.root[34:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {w.root[34:0], 1'b0};
        end
        o.num = {w.num[67:0], 2'b00};
        return o;
    endfunction

endpackage

@@ rtl/cflts_front.sv @@
module cflts_front
    import cflts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [30:0] i_density,
    input  logic [31:0] i_momentum_x,
    input  logic [31:0] i_momentum_y,
    input  logic [30:0] i_total_energy,
    input  logic [31:0] i_contra_vel_xi,
    input  logic [31:0] i_contra_vel_eta,
    input  logic [31:0] i_xi_dx,
    input  logic [31:0] i_xi_dy,
    input  logic [31:0] i_eta_dx,
    input  logic [31:0] i_eta_dy,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_item       o_q_item
);

    typedef struct packed {
        logic        zero;
        logic [30:0] rho;
        logic [30:0] e;
        logic [31:0] vxi;
        logic [31:0] veta;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] xdx;
        logic [31:0] xdy;
        logic [31:0] edx;
        logic [31:0] edy;
    } t_mag;

    typedef struct packed {
        logic        zero;
        logic [30:0] rho;
        logic [30:0] e;
        logic [31:0] vxi;
        logic [31:0] veta;
        logic [63:0] mx2;
        logic [63:0] my2;
        logic [63:0] xdx2;
        logic [63:0] xdy2;
        logic [63:0] edx2;
        logic [63:0] edy2;
    } t_sqr;

    logic  w_adv;
    logic  r_v1, r_v2, r_v3;
    t_mag  r_s1;
    t_sqr  r_s2;
    t_item r_s3;

    // Everything moves together; bubbles simply flow through.
    assign w_adv    = !i_q_full;
    assign o_full   = !w_adv;
    assign o_q_push = r_v3 && w_adv;
    assign o_q_item = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1.zero <= (i_density == 31'd0);
            r_s1.rho  <= i_density;
            r_s1.e    <= i_total_energy;
            r_s1.vxi  <= mag32(i_contra_vel_xi);
            r_s1.veta <= mag32(i_contra_vel_eta);
            r_s1.mx   <= mag32(i_momentum_x);
            r_s1.my   <= mag32(i_momentum_y);
            r_s1.xdx  <= mag32(i_xi_dx);
            r_s1.xdy  <= mag32(i_xi_dy);
            r_s1.edx  <= mag32(i_eta_dx);
            r_s1.edy  <= mag32(i_eta_dy);

            r_s2.zero <= r_s1.zero;
            r_s2.rho  <= r_s1.rho;
            r_s2.e    <= r_s1.e;
            r_s2.vxi  <= r_s1.vxi;
            r_s2.veta <= r_s1.veta;
            r_s2.mx2  <= r_s1.mx * r_s1.mx;
            r_s2.my2  <= r_s1.my * r_s1.my;
            r_s2.xdx2 <= r_s1.xdx * r_s1.xdx;
            r_s2.xdy2 <= r_s1.xdy * r_s1.xdy;
            r_s2.edx2 <= r_s1.edx * r_s1.edx;
            r_s2.edy2 <= r_s1.edy * r_s1.edy;

            r_s3.zero <= r_s2.zero;
            r_s3.rho  <= r_s2.rho;
            r_s3.e    <= r_s2.e;
            r_s3.vxi  <= r_s2.vxi;
            r_s3.veta <= r_s2.veta;
            r_s3.msq  <= r_s2.mx2 + r_s2.my2;
            r_s3.sqx  <= r_s2.xdx2 + r_s2.xdy2;
            r_s3.sqe  <= r_s2.edx2 + r_s2.edy2;
        end
    end

endmodule

@@ rtl/cflts_queue.sv @@
module cflts_queue
    import cflts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item              r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QPTR_W:0]    r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ rtl/cflts_back.sv @@
module cflts_back
    import cflts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [18:0] i_heat_ratio,
    input  logic [19:0] i_courant_number,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [30:0] o_time_step,
    output logic [1:0]  o_step_status
);

    t_work       r_st  [0:NUM_STAGES-1];
    logic        r_vld [0:NUM_STAGES-1];
    logic        w_adv;
    logic [30:0] w_dt;
    logic [1:0]  w_stat;
    logic [30:0] r_oq_dt [0:1];
    logic [1:0]  r_oq_st [0:1];
    logic        r_owp;
    logic        r_orp;
    logic [1:0]  r_ocnt;
    logic        w_opush;
    logic        w_opop;

    function automatic t_work load(input t_item it);
        t_work o;
        o          = '0;
        o.flag     = it.zero;
        o.stat     = it.zero ? ST_ZERO_RHO : ST_OK;
        o.rho      = it.rho;
        o.e        = it.e;
        o.vxi      = it.vxi;
        o.veta     = it.veta;
        o.dv.num   = it.msq;
        o.dv.den   = {32'd0, it.rho, 1'b0};
        o.sx.num   = {it.sqx, 6'd0};
        o.se.num   = {it.sqe, 6'd0};
        return o;
    endfunction

    function automatic t_work stage_fn(input int k, input t_work w,
                                       input logic [18:0] hr, input logic [19:0] cn);
        t_work       o;
        logic [18:0] g;
        logic [18:0] gm1;
        logic [30:0] pd;
        logic [49:0] pm;
        logic [52:0] gp;
        logic [62:0] c;
        o   = w;
        g   = (hr < ONE_HR) ? ONE_HR : hr;
        gm1 = g - ONE_HR;
        if (k <= DIV1_LAST) begin
            o.dv = div_step(w.dv);
            if (k <= SQM_LAST) begin
                o.sx = sq_step(w.sx);
                o.se = sq_step(w.se);
            end
        end else if (k == K_PRES) begin
            if (!w.flag && (w.dv.quo > 64'(w.e)) && (gm1 != '0)) begin
                o.flag = 1'b1;
                o.stat = ST_NEG_P;
            end
            pd   = (w.dv.quo > 64'(w.e)) ? '0 : w.e - w.dv.quo[30:0];
            pm   = gm1 * pd;
            o.pv = 34'(pm >> FRAC_BITS);
        end else if (k == K_GP) begin
            gp       = g * w.pv;
            o.dv.num = {gp, 11'd0};
            o.dv.rem = '0;
            o.dv.quo = '0;
            o.dv.den = 64'(w.rho);
        end else if (k <= DIV2_LAST) begin
            o.dv = div_step(w.dv);
        end else if (k == K_SQI) begin
            // Root of a2 scaled up by the fraction width keeps the result in Q16.16.
            o.sa.num  = {1'b0, w.dv.quo[52:0], 16'd0};
            o.sa.rem  = '0;
            o.sa.root = '0;
        end else if (k <= SQA_LAST) begin
            o.sa = sq_step(w.sa);
        end else if (k == K_MUL) begin
            o.px = w.sa.root[34:0] * w.sx.root[31:0];
            o.pe = w.sa.root[34:0] * w.se.root[31:0];
        end else if (k == K_SPD) begin
            // A product past 64 bits caps the speed; otherwise the sum stays far below the cap.
            o.tx = (w.px[66:64] != 3'd0) ? SPEED_CAP : 63'(w.vxi) + 63'(w.px[63:16]);
            o.te = (w.pe[66:64] != 3'd0) ? SPEED_CAP : 63'(w.veta) + 63'(w.pe[63:16]);
        end else if (k == K_MAX) begin
            c        = (w.tx > w.te) ? w.tx : w.te;
            o.dv.num = {cn, 16'd0, 28'd0};
            o.dv.rem = '0;
            o.dv.quo = '0;
            o.dv.den = 64'(c);
        end else begin
            o.dv = div_step(w.dv);
        end
        return o;
    endfunction

    assign w_adv   = (r_ocnt != 2'd2);
    assign o_q_pop = w_adv && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= load(i_q_item);
        end
    end

    genvar k;
    for (k = 1; k < NUM_STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[k] <= stage_fn(k, r_st[k-1], i_heat_ratio, i_courant_number);
            end
        end
    end

    always_comb begin
        if (r_st[NUM_STAGES-1].flag) begin
            w_dt   = '0;
            w_stat = r_st[NUM_STAGES-1].stat;
        end else if ((r_st[NUM_STAGES-1].dv.den == '0) ||
                     (r_st[NUM_STAGES-1].dv.quo > 64'(DT_MAX))) begin
            w_dt   = DT_MAX;
            w_stat = ST_SAT;
        end else begin
            w_dt   = r_st[NUM_STAGES-1].dv.quo[30:0];
            w_stat = ST_OK;
        end
    end

    // Two-entry result queue decouples the pipeline from the consumer.
    assign w_opush       = w_adv && r_vld[NUM_STAGES-1];
    assign w_opop        = pop && !empty;
    assign empty         = (r_ocnt == 2'd0);
    assign o_time_step   = r_oq_dt[r_orp];
    assign o_step_status = r_oq_st[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_opush) begin
                r_owp <= !r_owp;
            end
            if (w_opop) begin
                r_orp <= !r_orp;
            end
            if (w_opush && !w_opop) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (w_opop && !w_opush) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_oq_dt[r_owp] <= w_dt;
            r_oq_st[r_owp] <= w_stat;
        end
    end

endmodule

@@ rtl/cfl_local_time_step.sv @@
// A push beat passes the front stages, the four-entry queue, the back stages and the
// two-entry result queue before its result shows on the outputs.
// Throughput: one beat per cycle unless the result queue is full; every divide and
// square root is unrolled one quotient bit or root digit per pipeline stage, so a new point enters each cycle.
// A four-entry queue joins the front and the back, and a two-entry queue holds results.
// Reset (synchronous, active low) empties both queues and the pipelines and sets
// gamma to 1.4 and the CFL number to 1.0.
module cfl_local_time_step
    import cflts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [30:0] i_density,
    input  logic [31:0] i_momentum_x,
    input  logic [31:0] i_momentum_y,
    input  logic [30:0] i_total_energy,
    input  logic [31:0] i_contra_vel_xi,
    input  logic [31:0] i_contra_vel_eta,
    input  logic [31:0] i_xi_dx,
    input  logic [31:0] i_xi_dy,
    input  logic [31:0] i_eta_dx,
    input  logic [31:0] i_eta_dy,
    output logic        empty,
    input  logic        pop,
    output logic [30:0] o_time_step,
    output logic [1:0]  o_step_status
);

    logic [18:0] r_heat_ratio;
    logic [19:0] r_courant_number;
    logic        w_q_full;
    logic        w_q_push;
    t_item       w_q_in;
    logic        w_q_pop;
    logic        w_q_empty;
    t_item       w_q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_ratio     <= 19'd91750;
            r_courant_number <= 20'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEAT_RATIO: r_heat_ratio     <= i_cfg_data[18:0];
                CFG_COURANT:    r_courant_number <= i_cfg_data;
                default:        r_courant_number <= r_courant_number;
            endcase
        end
    end

    cflts_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_density        (i_density),
        .i_momentum_x     (i_momentum_x),
        .i_momentum_y     (i_momentum_y),
        .i_total_energy   (i_total_energy),
        .i_contra_vel_xi  (i_contra_vel_xi),
        .i_contra_vel_eta (i_contra_vel_eta),
        .i_xi_dx          (i_xi_dx),
        .i_xi_dy          (i_xi_dy),
        .i_eta_dx         (i_eta_dx),
        .i_eta_dy         (i_eta_dy),
        .i_q_full         (w_q_full),
        .o_q_push         (w_q_push),
        .o_q_item         (w_q_in)
    );

    cflts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_out)
    );

    cflts_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_heat_ratio     (r_heat_ratio),
        .i_courant_number (r_courant_number),
        .i_q_empty        (w_q_empty),
        .i_q_item         (w_q_out),
        .o_q_pop          (w_q_pop),
        .empty            (empty),
        .pop              (pop),
        .o_time_step      (o_time_step),
        .o_step_status    (o_step_status)
    );

endmodule

@@ rtl/cflts_checker.sv @@
module cflts_checker
    import cflts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [30:0] o_time_step,
    input logic [1:0]  o_step_status
);

    // Reset leaves both queues empty.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // Flagged points carry a zero time step.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_step_status == ST_ZERO_RHO || o_step_status == ST_NEG_P))
            |-> (o_time_step == 31'd0))
        else $error("flagged result with nonzero time step");

    // Saturation always reports the largest time step.
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_step_status == ST_SAT) |-> (o_time_step == DT_MAX))
        else $error("saturated result below maximum");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_time_step) && $stable(o_step_status)))
        else $error("waiting result changed");

endmodule

bind cfl_local_time_step cflts_checker u_checker (.*);

@@ tb/cfl_local_time_step_tb.sv @@
`timescale 1ns / 100ps

module cfl_local_time_step_tb;
    import cflts_pkg::*;

    typedef struct {
        logic [30:0] rho;
        logic [31:0] mx;
        logic [31:0] my;
        logic [30:0] e;
        logic [31:0] vxi;
        logic [31:0] veta;
        logic [31:0] xdx;
        logic [31:0] xdy;
        logic [31:0] edx;
        logic [31:0] edy;
    } point_t;

    typedef struct {
        logic [30:0] dt;
        logic [1:0]  st;
    } step_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 250;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [19:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [30:0] i_density;
    logic [31:0] i_momentum_x;
    logic [31:0] i_momentum_y;
    logic [30:0] i_total_energy;
    logic [31:0] i_contra_vel_xi;
    logic [31:0] i_contra_vel_eta;
    logic [31:0] i_xi_dx;
    logic [31:0] i_xi_dy;
    logic [31:0] i_eta_dx;
    logic [31:0] i_eta_dy;
    logic        empty;
    logic        pop;
    logic [30:0] o_time_step;
    logic [1:0]  o_step_status;

    logic [18:0] gamma_q;
    logic [19:0] cfl_q;
    step_t       step_expect_q[$];
    int          mismatches;
    int          idle_cycles;
    bit          gaps_on;
    bit          stalls_on;

    cfl_local_time_step dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_floor(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic [31:0] v);
        return {32'd0, v[31] ? (~v + 32'd1) : v};
    endfunction

    function automatic logic [63:0] speed(input logic [31:0] vel, input logic [63:0] a,
                                          input logic [63:0] n);
        logic [127:0] prod;
        logic [127:0] t;
        prod = {64'd0, a} * {64'd0, n};
        if (prod > 128'hffff_ffff_ffff_ffff) return {1'b0, SPEED_CAP};
        t = {64'd0, mag(vel)} + (prod >> FRAC_BITS);
        return (t > {65'd0, SPEED_CAP}) ? {1'b0, SPEED_CAP} : t[63:0];
    endfunction

    function automatic step_t predict_time_step(input point_t pt);
        step_t       r;
        logic [63:0] mx, my, ke, g, gm1, p, a2, a, nx, ne, t1, t2, c, q;
        logic [63:0] one;
        one = 64'd1 << FRAC_BITS;
        if (pt.rho == 0) begin
            r.dt = '0;
            r.st = ST_ZERO_RHO;
            return r;
        end
        mx  = mag(pt.mx);
        my  = mag(pt.my);
        ke  = (mx * mx + my * my) / (64'd2 * pt.rho);
        g   = (gamma_q < one) ? one : {45'd0, gamma_q};
        gm1 = g - one;
        if (ke > pt.e && gm1 != 0) begin
            r.dt = '0;
            r.st = ST_NEG_P;
            return r;
        end
        p  = (ke > pt.e) ? 64'd0 : ((gm1 * (pt.e - ke)) >> FRAC_BITS);
        a2 = (g * p) / pt.rho;
        a  = root_floor({64'd0, a2} << FRAC_BITS);
        nx = root_floor({64'd0, mag(pt.xdx) * mag(pt.xdx) + mag(pt.xdy) * mag(pt.xdy)});
        ne = root_floor({64'd0, mag(pt.edx) * mag(pt.edx) + mag(pt.edy) * mag(pt.edy)});
        t1 = speed(pt.vxi, a, nx);
        t2 = speed(pt.veta, a, ne);
        c  = (t1 > t2) ? t1 : t2;
        r.st = ST_OK;
        if (c == 0) begin
            r.dt = DT_MAX;
            r.st = ST_SAT;
        end else begin
            q = ({44'd0, cfl_q} << FRAC_BITS) / c;
            if (q > DT_MAX) begin
                r.dt = DT_MAX;
                r.st = ST_SAT;
            end else begin
                r.dt = q[30:0];
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Magnitudes spread over all scales, random sign.
    function automatic logic [31:0] rand_s32();
        logic [31:0] v;
        int k;
        k = $urandom_range(0, 49);
        if (k == 0) return 32'h8000_0000;
        if (k == 1) return 32'h7fff_ffff;
        if (k == 2) return 32'h0;
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [30:0] rand_u31();
        int k;
        k = $urandom_range(0, 49);
        if (k == 0) return 31'h0;
        if (k == 1) return 31'h7fff_ffff;
        return 31'($urandom >> $urandom_range(1, 31));
    endfunction

    function automatic point_t rand_point();
        point_t pt;
        pt.rho  = rand_u31();
        pt.mx   = rand_s32();
        pt.my   = rand_s32();
        pt.vxi  = rand_s32();
        pt.veta = rand_s32();
        pt.xdx  = rand_s32();
        pt.xdy  = rand_s32();
        pt.edx  = rand_s32();
        pt.edy  = rand_s32();
        // Mostly physical points: small momenta against a large energy.
        if ($urandom_range(0, 3) != 0) begin
            pt.rho = 31'($urandom) | 31'h100;
            pt.mx  = 32'($signed(pt.mx) >>> $urandom_range(8, 20));
            pt.my  = 32'($signed(pt.my) >>> $urandom_range(8, 20));
            pt.e   = 31'($urandom >> $urandom_range(1, 8));
        end else begin
            pt.e = rand_u31();
        end
        return pt;
    endfunction

    task automatic send_point(input point_t pt);
        bit f;
        int g;
        g = gaps_on ? gap_len() : 0;
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_density        <= pt.rho;
        i_momentum_x     <= pt.mx;
        i_momentum_y     <= pt.my;
        i_total_energy   <= pt.e;
        i_contra_vel_xi  <= pt.vxi;
        i_contra_vel_eta <= pt.veta;
        i_xi_dx          <= pt.xdx;
        i_xi_dy          <= pt.xdy;
        i_eta_dx         <= pt.edx;
        i_eta_dy         <= pt.edy;
        do begin
            @(negedge i_clk);
            f = full;
            @(posedge i_clk);
        end while (f);
        step_expect_q.push_back(predict_time_step(pt));
        idle_cycles = 0;
    endtask

    task automatic end_burst();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (step_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [19:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEAT_RATIO) gamma_q = data[18:0];
        else cfl_q = data;
        @(posedge i_clk);
    endtask

    task automatic send_mk(input logic [30:0] rho, input logic [31:0] m, input logic [30:0] e,
                           input logic [31:0] v, input logic [31:0] d);
        point_t pt;
        pt = '{rho, m, m, e, v, v, d, d, d, d};
        send_point(pt);
    endtask

    task automatic test_directed();
        send_mk(31'd0, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_mk(31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_mk(31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        // Momentum far above energy: negative pressure.
        send_mk(31'd1, 32'h8000_0000, 31'd0, 32'd65536, 32'd65536);
        // Everything at rest: zero speed.
        send_mk(31'd65536, 32'd0, 31'd0, 32'd0, 32'd0);
        // Tiny speed: the time step overflows.
        send_mk(31'd65536, 32'd0, 31'd0, 32'd1, 32'd0);
        // Huge sound speed times huge metrics.
        send_mk(31'd1, 32'd0, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_mk(31'd65536, 32'hffff_0000, 31'd65536, 32'd0, 32'd65536);
        send_mk(31'd65536, 32'd65536, 31'd98304, 32'hfffe_0000, 32'h0002_0000);
        send_mk(31'd1, 32'd1, 31'd1, 32'd1, 32'd1);
        for (int i = 0; i < 8; i++) send_point(rand_point());
        end_burst();
    endtask

    task automatic test_config_sweep();
        logic [19:0] hr_set[6];
        logic [19:0] cn_set[6];
        hr_set = '{20'd0, 20'd65535, 20'd65536, 20'd262144, 20'h7ffff, 20'hfffff};
        cn_set = '{20'd0, 20'd65536, 20'd655360, 20'hfffff, 20'd1, 20'd32768};
        for (int s = 0; s < 6; s++) begin
            drain();
            write_reg(CFG_HEAT_RATIO, hr_set[s]);
            write_reg(CFG_COURANT, cn_set[s]);
            for (int i = 0; i < 40; i++) send_point(rand_point());
            end_burst();
        end
        drain();
        write_reg(CFG_HEAT_RATIO, 20'd91750);
        write_reg(CFG_COURANT, 20'd65536);
    endtask

    task automatic test_random();
        for (int blk = 0; blk < 12; blk++) begin
            gaps_on   = (blk % 4) != 1;
            stalls_on = (blk % 4) != 2;
            if (blk % 3 == 2) begin
                drain();
                write_reg(CFG_HEAT_RATIO, 20'($urandom_range(65536, 262144)));
                write_reg(CFG_COURANT, 20'($urandom_range(0, 655360)));
            end
            for (int i = 0; i < 90; i++) send_point(rand_point());
        end
        end_burst();
    endtask

    // The sender holds off until the pipeline has fully drained, then bursts.
    task automatic test_drain_pause();
        drain();
        gaps_on = 1'b0;
        for (int i = 0; i < 80; i++) send_point(rand_point());
        end_burst();
        gaps_on = 1'b1;
    endtask

    initial begin : result_check
        step_t exp_r;
        int    stall;
        stall = 0;
        pop   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                if (stalls_on) stall = gap_len();
            end
            @(negedge i_clk);
            if (pop && !empty && i_rst_n) begin
                idle_cycles = 0;
                if (step_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat: dt %0d status %0d",
                                 o_time_step, o_step_status);
                end else begin
                    exp_r = step_expect_q.pop_front();
                    if (o_time_step !== exp_r.dt || o_step_status !== exp_r.st) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: dt exp %0d got %0d, status exp %0d got %0d",
                                     exp_r.dt, o_time_step, exp_r.st, o_step_status);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= 1'b0;
        i_cfg_data       <= '0;
        push             <= 1'b0;
        i_density        <= '0;
        i_momentum_x     <= '0;
        i_momentum_y     <= '0;
        i_total_energy   <= '0;
        i_contra_vel_xi  <= '0;
        i_contra_vel_eta <= '0;
        i_xi_dx          <= '0;
        i_xi_dy          <= '0;
        i_eta_dx         <= '0;
        i_eta_dy         <= '0;
        gamma_q    = 19'd91750;
        cfl_q      = 20'd65536;
        mismatches = 0;
        gaps_on    = 1'b1;
        stalls_on  = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_drain_pause();
        test_random();
        drain();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
